// ===== rtl/pngenc_pkg.sv =====
// shared types, codes and byte-sequence tables of the png stored rgba encoder
package pngenc_pkg;

    localparam int DEF_MAX_SIDE = 128;
    localparam int RAW_W = 17;

    localparam logic CMD_START = 1'b0;

    localparam logic [15:0] ADLER_MOD = 16'd65521;
    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;
    localparam logic [15:0] BLOCK_MAX = 16'hFFFF;

    localparam logic [5:0] START_LAST = 6'd47;
    localparam logic [5:0] TRAIL_LAST = 6'd19;
    localparam logic [5:0] HDR_LAST = 6'd4;
    localparam logic [2:0] RAW_FILTER = 3'd0;
    localparam logic [2:0] RAW_RED = 3'd1;
    localparam logic [2:0] RAW_ALPHA = 3'd4;

    localparam logic [2:0] SRC_CONST = 3'd0;
    localparam logic [2:0] SRC_WIDTH = 3'd1;
    localparam logic [2:0] SRC_HEIGHT = 3'd2;
    localparam logic [2:0] SRC_CRC = 3'd3;
    localparam logic [2:0] SRC_IDAT = 3'd4;
    localparam logic [2:0] SRC_ADLER = 3'd5;
    localparam logic [2:0] SRC_HDR = 3'd6;
    localparam logic [2:0] SRC_RAW = 3'd7;

    typedef struct packed {
        logic [2:0] src;
        logic [2:0] bidx;
        logic [7:0] cval;
        logic       crc_upd;
        logic       crc_init;
    } step_t;

    typedef struct packed {
        logic  emit;
        step_t step;
        logic  raw;
        logic  hdr_last;
        logic  pix_end;
        logic  run_last;
        logic  img_end;
        logic  frame_start;
        logic  load_pix;
        logic  frame_end;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
        logic need_hdr;
        logic col_zero;
        logic last_pixel;
        logic frame_active;
    } dp_status_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
        end
        return c;
    endfunction

    // signature, ihdr, idat head, zlib header, first block header
    function automatic step_t start_step(input logic [5:0] idx);
        step_t s;
        logic [5:0] d;
        s = '0;
        d = 6'd0;
        s.crc_upd = ((idx >= 6'd12) && (idx <= 6'd28)) || ((idx >= 6'd37) && (idx <= 6'd47));
        s.crc_init = (idx == 6'd12) || (idx == 6'd37);
        s.src = SRC_CONST;
        unique case (idx)
            6'd0: s.cval = 8'h89;
            6'd1: s.cval = 8'h50;
            6'd2: s.cval = 8'h4E;
            6'd3: s.cval = 8'h47;
            6'd4: s.cval = 8'h0D;
            6'd5: s.cval = 8'h0A;
            6'd6: s.cval = 8'h1A;
            6'd7: s.cval = 8'h0A;
            6'd11: s.cval = 8'h0D;
            6'd12: s.cval = 8'h49;
            6'd13: s.cval = 8'h48;
            6'd14: s.cval = 8'h44;
            6'd15: s.cval = 8'h52;
            6'd19: s.src = SRC_WIDTH;
            6'd23: s.src = SRC_HEIGHT;
            6'd24: s.cval = 8'h08;
            6'd25: s.cval = 8'h06;
            6'd29, 6'd30, 6'd31, 6'd32:
            begin
                s.src = SRC_CRC;
                d = idx - 6'd29;
                s.bidx = d[2:0];
            end
            6'd33, 6'd34, 6'd35, 6'd36:
            begin
                s.src = SRC_IDAT;
                d = idx - 6'd33;
                s.bidx = d[2:0];
            end
            6'd37: s.cval = 8'h49;
            6'd38: s.cval = 8'h44;
            6'd39: s.cval = 8'h41;
            6'd40: s.cval = 8'h54;
            6'd41: s.cval = 8'h78;
            6'd42: s.cval = 8'h01;
            6'd43, 6'd44, 6'd45, 6'd46, 6'd47:
            begin
                s.src = SRC_HDR;
                d = idx - 6'd43;
                s.bidx = d[2:0];
            end
            default: s.cval = 8'h00;
        endcase
        return s;
    endfunction

    // adler, idat crc, iend chunk
    function automatic step_t trail_step(input logic [5:0] idx);
        step_t s;
        logic [5:0] d;
        s = '0;
        d = 6'd0;
        s.crc_upd = (idx <= 6'd3) || ((idx >= 6'd12) && (idx <= 6'd15));
        s.crc_init = (idx == 6'd12);
        s.src = SRC_CONST;
        unique case (idx)
            6'd0, 6'd1, 6'd2, 6'd3:
            begin
                s.src = SRC_ADLER;
                s.bidx = idx[2:0];
            end
            6'd4, 6'd5, 6'd6, 6'd7:
            begin
                s.src = SRC_CRC;
                d = idx - 6'd4;
                s.bidx = d[2:0];
            end
            6'd12: s.cval = 8'h49;
            6'd13: s.cval = 8'h45;
            6'd14: s.cval = 8'h4E;
            6'd15: s.cval = 8'h44;
            6'd16, 6'd17, 6'd18, 6'd19:
            begin
                s.src = SRC_CRC;
                d = idx - 6'd16;
                s.bidx = d[2:0];
            end
            default: s.cval = 8'h00;
        endcase
        return s;
    endfunction

endpackage

// ===== rtl/pngenc_dp.sv =====
// datapath: crc, adler, counters, byte selection and output register
module pngenc_dp
    import pngenc_pkg::*;
#(
    parameter int MAX_SIDE = DEF_MAX_SIDE
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  ctrl_cmd_t   ctl,
    input  logic [31:0] pixel_argb,
    input  logic [7:0]  cfg_width,
    input  logic [7:0]  cfg_height,
    input  logic        out_stall,
    output dp_status_t  status,
    output logic        out_valid,
    output logic [7:0]  out_byte,
    output logic        run_last,
    output logic        image_end
);

    localparam int COL_W = (MAX_SIDE > 2) ? $clog2(MAX_SIDE) : 1;
    localparam logic [7:0] SIDE_MAX = 8'(MAX_SIDE);

    logic             active_reg, active_next;
    logic [31:0]      crc_reg, crc_next;
    logic [15:0]      alow_reg, alow_next;
    logic [15:0]      ahigh_reg, ahigh_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [7:0]       row_reg, row_next;
    logic [RAW_W-1:0] raw_left_reg, raw_left_next;
    logic [15:0]      blk_left_reg, blk_left_next;
    logic [7:0]       fw_reg, fw_next;
    logic [7:0]       fh_reg, fh_next;
    logic [31:0]      pix_reg, pix_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg, out_byte_next;
    logic             run_last_reg, run_last_next;
    logic             image_end_reg, image_end_next;

    logic [7:0]  w_c, h_c;
    logic [17:0] prod;
    logic [31:0] idat_len;
    logic [15:0] blen;
    logic        bfinal;
    logic [7:0]  hdr_byte;
    logic [7:0]  raw_byte;
    logic [7:0]  cur_byte;
    logic [31:0] crc_base;
    logic [16:0] lsum, hsum;
    logic [15:0] low_n, high_n;
    logic [8:0]  col_inc;
    logic [8:0]  row_inc;
    logic        row_done, frame_done;

    function automatic logic [7:0] clamp_side(input logic [7:0] v);
        if (v == 8'd0)
            return 8'd1;
        else if (v > SIDE_MAX)
            return SIDE_MAX;
        else
            return v;
    endfunction

    function automatic logic [7:0] word_byte(input logic [31:0] w, input logic [2:0] b);
        logic [7:0] r;
        unique case (b[1:0])
            2'd0: r = w[31:24];
            2'd1: r = w[23:16];
            2'd2: r = w[15:8];
            2'd3: r = w[7:0];
            default: r = 8'd0;
        endcase
        return r;
    endfunction

    always_comb
    begin
        w_c = clamp_side(cfg_width);
        h_c = clamp_side(cfg_height);
        prod = 18'(h_c) * 18'({w_c, 2'b01});
        idat_len = 32'(raw_left_reg) + ((raw_left_reg > RAW_W'(BLOCK_MAX)) ? 32'd16 : 32'd11);

        bfinal = (raw_left_reg <= RAW_W'(BLOCK_MAX));
        blen = bfinal ? raw_left_reg[15:0] : BLOCK_MAX;
        unique case (ctl.step.bidx)
            3'd0: hdr_byte = {7'd0, bfinal};
            3'd1: hdr_byte = blen[7:0];
            3'd2: hdr_byte = blen[15:8];
            3'd3: hdr_byte = ~blen[7:0];
            3'd4: hdr_byte = ~blen[15:8];
            default: hdr_byte = 8'd0;
        endcase

        unique case (ctl.step.bidx)
            RAW_FILTER: raw_byte = 8'd0;
            RAW_RED: raw_byte = pix_reg[23:16];
            3'd2: raw_byte = pix_reg[15:8];
            3'd3: raw_byte = pix_reg[7:0];
            RAW_ALPHA: raw_byte = pix_reg[31:24];
            default: raw_byte = 8'd0;
        endcase

        unique case (ctl.step.src)
            SRC_CONST: cur_byte = ctl.step.cval;
            SRC_WIDTH: cur_byte = fw_reg;
            SRC_HEIGHT: cur_byte = fh_reg;
            SRC_CRC: cur_byte = word_byte(~crc_reg, ctl.step.bidx);
            SRC_IDAT: cur_byte = word_byte(idat_len, ctl.step.bidx);
            SRC_ADLER: cur_byte = word_byte({ahigh_reg, alow_reg}, ctl.step.bidx);
            SRC_HDR: cur_byte = hdr_byte;
            SRC_RAW: cur_byte = raw_byte;
            default: cur_byte = 8'd0;
        endcase

        crc_base = ctl.step.crc_init ? CRC_ONES : crc_reg;
        lsum = {1'b0, alow_reg} + {9'd0, cur_byte};
        low_n = (lsum >= {1'b0, ADLER_MOD}) ? 16'(lsum - {1'b0, ADLER_MOD}) : lsum[15:0];
        hsum = {1'b0, ahigh_reg} + {1'b0, low_n};
        high_n = (hsum >= {1'b0, ADLER_MOD}) ? 16'(hsum - {1'b0, ADLER_MOD}) : hsum[15:0];

        col_inc = 9'(col_reg) + 9'd1;
        row_inc = {1'b0, row_reg} + 9'd1;
        row_done = (col_inc >= {1'b0, fw_reg});
        frame_done = row_done && (row_inc >= {1'b0, fh_reg});
    end

    always_comb
    begin
        active_next = active_reg;
        crc_next = crc_reg;
        alow_next = alow_reg;
        ahigh_next = ahigh_reg;
        col_next = col_reg;
        row_next = row_reg;
        raw_left_next = raw_left_reg;
        blk_left_next = blk_left_reg;
        fw_next = fw_reg;
        fh_next = fh_reg;
        pix_next = pix_reg;
        out_valid_next = out_stall ? out_valid_reg : 1'b0;
        out_byte_next = out_byte_reg;
        run_last_next = run_last_reg;
        image_end_next = image_end_reg;

        if (ctl.frame_start)
        begin
            fw_next = w_c;
            fh_next = h_c;
            raw_left_next = prod[RAW_W-1:0];
            blk_left_next = 16'd0;
            alow_next = 16'd1;
            ahigh_next = 16'd0;
            col_next = '0;
            row_next = 8'd0;
            active_next = 1'b1;
        end

        if (ctl.load_pix)
            pix_next = pixel_argb;

        if (ctl.emit)
        begin
            out_valid_next = 1'b1;
            out_byte_next = cur_byte;
            run_last_next = ctl.run_last;
            image_end_next = ctl.img_end;
            if (ctl.step.crc_upd)
                crc_next = crc_byte(crc_base, cur_byte);
            if (ctl.hdr_last)
                blk_left_next = blen;
            if (ctl.raw)
            begin
                alow_next = low_n;
                ahigh_next = high_n;
                if (blk_left_reg != 16'd0)
                    blk_left_next = blk_left_reg - 16'd1;
                if (raw_left_reg != '0)
                    raw_left_next = raw_left_reg - RAW_W'(1);
            end
            if (ctl.pix_end)
            begin
                if (row_done)
                begin
                    col_next = '0;
                    row_next = frame_done ? 8'd0 : row_inc[7:0];
                end
                else
                begin
                    col_next = col_inc[COL_W-1:0];
                end
            end
            if (ctl.frame_end)
            begin
                active_next = 1'b0;
                raw_left_next = '0;
                blk_left_next = 16'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            crc_reg <= CRC_ONES;
            alow_reg <= 16'd1;
            ahigh_reg <= 16'd0;
            col_reg <= '0;
            row_reg <= 8'd0;
            raw_left_reg <= '0;
            blk_left_reg <= 16'd0;
            fw_reg <= 8'd1;
            fh_reg <= 8'd1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            crc_reg <= crc_next;
            alow_reg <= alow_next;
            ahigh_reg <= ahigh_next;
            col_reg <= col_next;
            row_reg <= row_next;
            raw_left_reg <= raw_left_next;
            blk_left_reg <= blk_left_next;
            fw_reg <= fw_next;
            fh_reg <= fh_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pix_reg <= pix_next;
        out_byte_reg <= out_byte_next;
        run_last_reg <= run_last_next;
        image_end_reg <= image_end_next;
    end

    assign status.out_free = !out_valid_reg || !out_stall;
    assign status.need_hdr = (blk_left_reg == 16'd0) && (raw_left_reg != '0);
    assign status.col_zero = (col_reg == '0);
    assign status.last_pixel = frame_done;
    assign status.frame_active = active_reg;

    assign out_valid = out_valid_reg;
    assign out_byte = out_byte_reg;
    assign run_last = run_last_reg;
    assign image_end = image_end_reg;

`ifndef NO_ASSERTIONS
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && image_end_reg |-> run_last_reg)
        else $error("image end without run end");
    a_block_in_raw: assert property (@(posedge clk) disable iff (!rst_n)
        RAW_W'(blk_left_reg) <= raw_left_reg)
        else $error("block count beyond raw count");
    a_adler_range: assert property (@(posedge clk) disable iff (!rst_n)
        (alow_reg < ADLER_MOD) && (ahigh_reg < ADLER_MOD))
        else $error("adler out of range");
`endif

endmodule

// ===== rtl/pngenc_ctrl.sv =====
// controller: sequences the bytes of each transaction
module pngenc_ctrl
    import pngenc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       cmd,
    output logic       in_stall,
    input  dp_status_t status,
    output ctrl_cmd_t  ctl
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_START = 3'd1;
    localparam logic [2:0] ST_RAW = 3'd2;
    localparam logic [2:0] ST_HDR = 3'd3;
    localparam logic [2:0] ST_TRAIL = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [5:0] idx_reg, idx_next;
    logic [2:0] k_reg, k_next;

    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg;
        k_next = k_reg;
        ctl = '0;
        in_stall = (state_reg != ST_IDLE);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (cmd == CMD_START)
                    begin
                        ctl.frame_start = 1'b1;
                        idx_next = 6'd0;
                        state_next = ST_START;
                    end
                    else if (status.frame_active)
                    begin
                        ctl.load_pix = 1'b1;
                        k_next = status.col_zero ? RAW_FILTER : RAW_RED;
                        state_next = ST_RAW;
                    end
                end
            end
            ST_START:
            begin
                if (status.out_free)
                begin
                    ctl.emit = 1'b1;
                    ctl.step = start_step(idx_reg);
                    if (idx_reg == START_LAST)
                    begin
                        ctl.hdr_last = 1'b1;
                        ctl.run_last = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 6'd1;
                    end
                end
            end
            ST_RAW:
            begin
                if (status.out_free)
                begin
                    ctl.emit = 1'b1;
                    ctl.step.crc_upd = 1'b1;
                    if (status.need_hdr)
                    begin
                        ctl.step.src = SRC_HDR;
                        ctl.step.bidx = 3'd0;
                        idx_next = 6'd1;
                        state_next = ST_HDR;
                    end
                    else
                    begin
                        ctl.step.src = SRC_RAW;
                        ctl.step.bidx = k_reg;
                        ctl.raw = 1'b1;
                        if (k_reg == RAW_ALPHA)
                        begin
                            ctl.pix_end = 1'b1;
                            idx_next = 6'd0;
                            if (status.last_pixel)
                            begin
                                state_next = ST_TRAIL;
                            end
                            else
                            begin
                                ctl.run_last = 1'b1;
                                state_next = ST_IDLE;
                            end
                        end
                        else
                        begin
                            k_next = k_reg + 3'd1;
                        end
                    end
                end
            end
            ST_HDR:
            begin
                if (status.out_free)
                begin
                    ctl.emit = 1'b1;
                    ctl.step.crc_upd = 1'b1;
                    ctl.step.src = SRC_HDR;
                    ctl.step.bidx = idx_reg[2:0];
                    if (idx_reg == HDR_LAST)
                    begin
                        ctl.hdr_last = 1'b1;
                        state_next = ST_RAW;
                    end
                    else
                    begin
                        idx_next = idx_reg + 6'd1;
                    end
                end
            end
            ST_TRAIL:
            begin
                if (status.out_free)
                begin
                    ctl.emit = 1'b1;
                    ctl.step = trail_step(idx_reg);
                    if (idx_reg == TRAIL_LAST)
                    begin
                        ctl.run_last = 1'b1;
                        ctl.img_end = 1'b1;
                        ctl.frame_end = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 6'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg <= 6'd0;
            k_reg <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg <= idx_next;
            k_reg <= k_next;
        end
    end

endmodule

// ===== rtl/png_stored_rgba_encoder.sv =====
// top level: apb registers, controller and datapath of the png stored rgba encoder
// a transaction is accepted in idle; its first byte is sent from the start or raw state into the output register
// throughput: one byte per cycle unless stalled, from the byte-wise crc-32 and adler-32 update
// start transaction: 48 bytes; pixel: 4 bytes, 5 at row start, 5 more at a block boundary
// last pixel adds 20 bytes; a new transaction is taken once the previous one is fully issued
// reset clears control state and counters, sets both size registers to 1; no clearing pass
module png_stored_rgba_encoder
    import pngenc_pkg::*;
#(
    parameter int MAX_SIDE = DEF_MAX_SIDE
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        cmd,
    input  logic [31:0] pixel_argb,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        run_last,
    output logic        image_end,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0] width_reg, width_next;
    logic [7:0] height_reg, height_next;
    logic       wr_en;
    ctrl_cmd_t  ctl;
    dp_status_t status;

    assign wr_en = psel && penable && pwrite;

    always_comb
    begin
        width_next = width_reg;
        height_next = height_reg;
        if (wr_en)
        begin
            if (paddr[2])
                height_next = pwdata[7:0];
            else
                width_next = pwdata[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= 8'd1;
            height_reg <= 8'd1;
        end
        else
        begin
            width_reg <= width_next;
            height_reg <= height_next;
        end
    end

    assign prdata = paddr[2] ? {24'd0, height_reg} : {24'd0, width_reg};
    assign pready = 1'b1;

    pngenc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .cmd      (cmd),
        .in_stall (in_stall),
        .status   (status),
        .ctl      (ctl)
    );

    pngenc_dp #(
        .MAX_SIDE (MAX_SIDE)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .pixel_argb (pixel_argb),
        .cfg_width  (width_reg),
        .cfg_height (height_reg),
        .out_stall  (out_stall),
        .status     (status),
        .out_valid  (out_valid),
        .out_byte   (out_byte),
        .run_last   (run_last),
        .image_end  (image_end)
    );

endmodule

// ===== sim/tb_png_stored_rgba_encoder.sv =====
// self-checking testbench of the png stored rgba encoder with a built-in byte predictor
`timescale 1ns / 100ps

module tb_png_stored_rgba_encoder
    import pngenc_pkg::*;
();

    localparam int SIDE_MAX = 128;
    localparam int CYCLE_LIMIT = 600000;
    localparam logic [2:0] ADDR_WIDTH = 3'd0;
    localparam logic [2:0] ADDR_HEIGHT = 3'd4;
    localparam logic CMD_PIXEL = 1'b1;

    typedef struct {
        logic        cmd;
        logic [31:0] argb;
    } pix_req_t;

    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       fin;
    } png_byte_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        cmd;
    logic [31:0] pixel_argb;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  out_byte;
    logic        run_last;
    logic        image_end;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    pix_req_t  req_q[$];
    png_byte_t png_q[$];
    png_byte_t step_q[$];

    int  errors = 0;
    int  cycles = 0;
    bit  idle_on = 1'b1;
    bit  hold_req = 1'b0;
    int  hold_left = 0;
    bit  in_taken = 1'b0;

    // predictor state
    logic [7:0]  reg_w = 8'd1;
    logic [7:0]  reg_h = 8'd1;
    bit          fr_act = 1'b0;
    logic [31:0] crc_r = 32'hFFFFFFFF;
    logic [31:0] adl_lo = 32'd1;
    logic [31:0] adl_hi = 32'd0;
    int          col_n = 0;
    int          row_n = 0;
    int          raw_left = 0;
    int          blk_left = 0;
    int          fw = 1;
    int          fh = 1;

    png_stored_rgba_encoder uut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd),
        .pixel_argb(pixel_argb), .out_valid(out_valid), .out_stall(out_stall),
        .out_byte(out_byte), .run_last(run_last), .image_end(image_end), .psel(psel),
        .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
        .prdata(prdata), .pready(pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int side_of(input logic [7:0] v);
        if (v == 8'd0)
            return 1;
        if (v > SIDE_MAX)
            return SIDE_MAX;
        return int'(v);
    endfunction

    task automatic emit(input logic [7:0] b);
        png_byte_t e;
        e.data = b;
        e.last = 1'b0;
        e.fin = 1'b0;
        step_q.insert(step_q.size(), e);
    endtask

    task automatic emit_crc(input logic [7:0] b);
        logic [31:0] c;
        c = crc_r ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? (32'hEDB88320 ^ (c >> 1)) : (c >> 1);
        end
        crc_r = c;
        emit(b);
    endtask

    task automatic emit_word(input logic [31:0] v, input bit chk);
        for (int s = 24; s >= 0; s -= 8)
        begin
            if (chk)
                emit_crc(v[s +: 8]);
            else
                emit(v[s +: 8]);
        end
    endtask

    task automatic emit_tag(input logic [31:0] t);
        crc_r = 32'hFFFFFFFF;
        emit_word(t, 1'b1);
    endtask

    task automatic emit_block_hdr();
        logic [15:0] len;
        logic [15:0] inv;
        len = (raw_left > 16'hFFFF) ? 16'hFFFF : raw_left[15:0];
        inv = ~len;
        emit_crc((raw_left <= 16'hFFFF) ? 8'd1 : 8'd0);
        emit_crc(len[7:0]);
        emit_crc(len[15:8]);
        emit_crc(inv[7:0]);
        emit_crc(inv[15:8]);
        blk_left = int'(len);
    endtask

    task automatic emit_raw(input logic [7:0] b);
        if (blk_left == 0 && raw_left > 0)
            emit_block_hdr();
        emit_crc(b);
        adl_lo = adl_lo + b;
        if (adl_lo >= 32'd65521)
            adl_lo = adl_lo - 32'd65521;
        adl_hi = adl_hi + adl_lo;
        if (adl_hi >= 32'd65521)
            adl_hi = adl_hi - 32'd65521;
        if (blk_left > 0)
            blk_left--;
        if (raw_left > 0)
            raw_left--;
    endtask

    task automatic open_image();
        int raw;
        int nblk;
        fw = side_of(reg_w);
        fh = side_of(reg_h);
        raw = fh * (1 + 4 * fw);
        nblk = (raw > 16'hFFFF) ? 2 : 1;
        emit(8'h89); emit(8'h50); emit(8'h4E); emit(8'h47);
        emit(8'h0D); emit(8'h0A); emit(8'h1A); emit(8'h0A);
        emit_word(32'd13, 1'b0);
        emit_tag(32'h49484452);
        emit_word(fw, 1'b1);
        emit_word(fh, 1'b1);
        emit_crc(8'd8); emit_crc(8'd6); emit_crc(8'd0); emit_crc(8'd0); emit_crc(8'd0);
        emit_word(crc_r ^ 32'hFFFFFFFF, 1'b0);
        emit_word(2 + 5 * nblk + raw + 4, 1'b0);
        emit_tag(32'h49444154);
        emit_crc(8'h78);
        emit_crc(8'h01);
        raw_left = raw;
        emit_block_hdr();
        adl_lo = 32'd1;
        adl_hi = 32'd0;
        col_n = 0;
        row_n = 0;
        fr_act = 1'b1;
    endtask

    task automatic add_pixel(input logic [31:0] p);
        if (col_n == 0)
            emit_raw(8'd0);
        emit_raw(p[23:16]);
        emit_raw(p[15:8]);
        emit_raw(p[7:0]);
        emit_raw(p[31:24]);
        if (col_n + 1 >= fw)
        begin
            col_n = 0;
            row_n++;
            if (row_n >= fh)
            begin
                emit_word({adl_hi[15:0], adl_lo[15:0]}, 1'b1);
                emit_word(crc_r ^ 32'hFFFFFFFF, 1'b0);
                emit_word(32'd0, 1'b0);
                emit_tag(32'h49454E44);
                emit_word(crc_r ^ 32'hFFFFFFFF, 1'b0);
                fr_act = 1'b0;
                row_n = 0;
                raw_left = 0;
                blk_left = 0;
                step_q[step_q.size() - 1].fin = 1'b1;
            end
        end
        else
            col_n = (col_n + 1) & 8'h7F;
    endtask

    task automatic predict_bytes(input pix_req_t r);
        step_q.delete();
        if (r.cmd == CMD_START)
            open_image();
        else if (fr_act)
            add_pixel(r.argb);
        if (step_q.size() > 0)
            step_q[step_q.size() - 1].last = 1'b1;
        foreach (step_q[i])
            png_q.insert(png_q.size(), step_q[i]);
    endtask

    // input driver
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            if (req_q.size() > 0 && !(idle_on && $urandom_range(99) < 12))
            begin
                pix_req_t r;
                r = req_q.pop_front();
                cmd <= r.cmd;
                pixel_argb <= r.argb;
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
        in_taken = 1'b0;
    end

    // output receiver
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_req = 1'b0;
            hold_left = 400;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= idle_on && ($urandom_range(99) < 12);
    end

    // monitor and checker
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        if (rst_n && in_valid && !in_stall)
        begin
            pix_req_t r;
            r.cmd = cmd;
            r.argb = pixel_argb;
            predict_bytes(r);
            in_taken = 1'b1;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (png_q.size() == 0)
            begin
                errors++;
                $display("%0t unexpected byte: expected none, actual %h", $time, out_byte);
            end
            else
            begin
                png_byte_t e;
                e = png_q.pop_front();
                if (out_byte !== e.data || run_last !== e.last || image_end !== e.fin)
                begin
                    errors++;
                    $display("%0t mismatch: expected %h/%b/%b, actual %h/%b/%b", $time,
                             e.data, e.last, e.fin, out_byte, run_last, image_end);
                end
            end
        end
    end

    task automatic wait_idle();
        while (req_q.size() > 0 || in_valid || png_q.size() > 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic reg_write(input logic [2:0] a, input logic [7:0] v);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= a;
        pwdata <= {8'($urandom_range(255)), 16'd0, v};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (prdata !== {24'd0, v} || pready !== 1'b1)
        begin
            errors++;
            $display("%0t register readback: expected %h, actual %h", $time, v, prdata[7:0]);
        end
        if (a == ADDR_WIDTH)
            reg_w = v;
        else
            reg_h = v;
    endtask

    task automatic queue_item(input logic c, input logic [31:0] p);
        pix_req_t r;
        r.cmd = c;
        r.argb = p;
        req_q.insert(req_q.size(), r);
    endtask

    task automatic queue_image(input int npix);
        queue_item(CMD_START, $urandom);
        for (int i = 0; i < npix; i++)
            queue_item(CMD_PIXEL, $urandom);
    endtask

    initial
    begin
        int sent;
        int w;
        int h;
        rst_n = 1'b0;
        in_valid = 1'b0;
        cmd = 1'b0;
        pixel_argb = 32'd0;
        out_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = 3'd0;
        pwdata = 32'd0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // stray pixel, then a 1x1 image at reset sizes, then another stray pixel
        queue_item(CMD_PIXEL, 32'hFFFFFFFF);
        queue_item(CMD_START, 32'h0);
        queue_item(CMD_PIXEL, 32'h00000000);
        queue_item(CMD_PIXEL, 32'hFFFFFFFF);
        wait_idle();

        // zero sizes treated as one
        reg_write(ADDR_WIDTH, 8'd0);
        reg_write(ADDR_HEIGHT, 8'd0);
        queue_item(CMD_START, 32'h0);
        queue_item(CMD_PIXEL, 32'hFFFFFFFF);
        wait_idle();

        // oversized sizes saturate; frame abandoned by a new start
        reg_write(ADDR_WIDTH, 8'd255);
        reg_write(ADDR_HEIGHT, 8'd200);
        queue_image(3);
        wait_idle();

        // size change while a frame is open only applies at the next start
        reg_write(ADDR_WIDTH, 8'd2);
        reg_write(ADDR_HEIGHT, 8'd1);
        queue_item(CMD_PIXEL, 32'hA5A5A5A5);
        queue_image(2);
        wait_idle();

        // single row with a long receiver hold-off
        reg_write(ADDR_WIDTH, 8'd16);
        reg_write(ADDR_HEIGHT, 8'd1);
        queue_image(16);
        repeat (5) @(posedge clk);
        hold_req = 1'b1;
        wait_idle();

        sent = 0;
        while (sent < 80)
        begin
            w = $urandom_range(4, 1);
            h = $urandom_range(3, 1);
            idle_on = !(sent >= 30 && sent < 60);
            reg_write(ADDR_WIDTH, 8'(w));
            reg_write(ADDR_HEIGHT, 8'(h));
            if ($urandom_range(9) < 8)
            begin
                queue_image(w * h);
                sent += 1 + w * h;
            end
            else
            begin
                queue_image($urandom_range(w * h - 1, 0));
                queue_item(CMD_PIXEL, $urandom);
                sent += 2;
            end
            if ($urandom_range(4) == 0)
                queue_item(CMD_PIXEL, $urandom);
            wait_idle();
        end

        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
